// ===== rtl/srds_pkg.sv =====
// Shared types, constants and multiplier tables of the sample rate divider search.
package srds_pkg;

	localparam int RATE_W    = 18;
	localparam int SCALE_W   = 8;
	localparam int BASE_W    = 17;
	localparam int MASK_W    = 16;
	localparam int MULT_W    = 8;
	localparam int NUM_BASES = 4;
	localparam int NUM_CODES = 16;
	localparam int BIDX_W    = 2;
	localparam int CIDX_W    = 4;
	localparam int IDX_W     = BIDX_W + CIDX_W;
	localparam int NEED_W    = RATE_W + SCALE_W;
	localparam int CAND_W    = BASE_W + MULT_W;
	localparam int WIN_W     = NEED_W + 1;
	localparam int SCORE_W   = NEED_W + 1;
	localparam int ERR_W     = 22;
	localparam int WORD_W    = 7;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	localparam int DEF_RATE_SCALE      = 132;
	localparam int DEF_HALF_FLAG_SHIFT = 6;
	localparam int WORD_HALF_BIT       = 6;

	localparam logic [BASE_W-1:0] RST_BASE_RATE_0 = BASE_W'(93750);
	localparam logic [BASE_W-1:0] RST_BASE_RATE_1 = BASE_W'(96000);
	localparam logic [BASE_W-1:0] RST_BASE_RATE_2 = BASE_W'(62500);
	localparam logic [BASE_W-1:0] RST_BASE_RATE_3 = BASE_W'(88235);
	localparam logic [MASK_W-1:0] RST_ALLOWED_0   = MASK_W'(36815);
	localparam logic [MASK_W-1:0] RST_ALLOWED_1   = MASK_W'(207);
	localparam logic [MASK_W-1:0] RST_ALLOWED_2   = MASK_W'(36815);
	localparam logic [MASK_W-1:0] RST_ALLOWED_3   = MASK_W'(36608);

	localparam logic [REG_IDX_W-1:0] REG_BASE_RATE_0    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BASE_RATE_1    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BASE_RATE_2    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BASE_RATE_3    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ALLOWED_CODES_0 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ALLOWED_CODES_1 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ALLOWED_CODES_2 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ALLOWED_CODES_3 = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEED,
		ST_WIN,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [NUM_BASES-1:0][BASE_W-1:0] base_rate;
		logic [NUM_BASES-1:0][MASK_W-1:0] allowed;
	} cfg_t;

	typedef struct packed {
		logic             load_in;
		logic             calc_need;
		logic             calc_win;
		logic             clear_best;
		logic             issue;
		logic [IDX_W-1:0] idx;
		logic             load_out;
	} ctrl_cmd_t;

	function automatic logic [MULT_W-1:0] adc_mult(input logic [CIDX_W-1:0] code);
		logic [MULT_W-1:0] m;
		case (code)
			4'd0, 4'd1, 4'd8, 4'd9: m = 8'd66;
			4'd2, 4'd3:             m = 8'd11;
			4'd6:                   m = 8'd44;
			4'd7, 4'd15:            m = 8'd132;
			4'd10, 4'd11:           m = 8'd12;
			default:                m = 8'd0;
		endcase
		return m;
	endfunction

	function automatic logic [MULT_W-1:0] dac_mult(input logic [CIDX_W-1:0] code);
		logic [MULT_W-1:0] m;
		case (code)
			4'd0, 4'd2, 4'd8, 4'd10: m = 8'd66;
			4'd1, 4'd3:              m = 8'd11;
			4'd6:                    m = 8'd44;
			4'd7, 4'd15:             m = 8'd132;
			4'd9, 4'd11:             m = 8'd12;
			default:                 m = 8'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/srds_in_if.sv =====
// Request channel: requested ADC and DAC rates with valid/ready.
interface srds_in_if import srds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] adc_rate;
	logic [RATE_W-1:0] dac_rate;

	modport source (output valid, adc_rate, dac_rate, input ready);
	modport sink (input valid, adc_rate, dac_rate, output ready);
endinterface

// ===== rtl/srds_out_if.sv =====
// Result channel: chosen base, code, divider flag, rate word and score.
interface srds_out_if import srds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [BIDX_W-1:0] base_index;
	logic [CIDX_W-1:0] code_index;
	logic              half_clock;
	logic [WORD_W-1:0] rate_word;
	logic [ERR_W-1:0]  best_error;

	modport source (output valid, found, base_index, code_index, half_clock, rate_word,
		best_error, input ready);
	modport sink (input valid, found, base_index, code_index, half_clock, rate_word,
		best_error, output ready);
endinterface

// ===== rtl/srds_regs.sv =====
// APB register file holding base rates and allowed code masks.
module srds_regs import srds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_rate[0] <= RST_BASE_RATE_0;
			cfg_q.base_rate[1] <= RST_BASE_RATE_1;
			cfg_q.base_rate[2] <= RST_BASE_RATE_2;
			cfg_q.base_rate[3] <= RST_BASE_RATE_3;
			cfg_q.allowed[0]   <= RST_ALLOWED_0;
			cfg_q.allowed[1]   <= RST_ALLOWED_1;
			cfg_q.allowed[2]   <= RST_ALLOWED_2;
			cfg_q.allowed[3]   <= RST_ALLOWED_3;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BASE_RATE_0:     cfg_q.base_rate[0] <= pwdata[BASE_W-1:0];
				REG_BASE_RATE_1:     cfg_q.base_rate[1] <= pwdata[BASE_W-1:0];
				REG_BASE_RATE_2:     cfg_q.base_rate[2] <= pwdata[BASE_W-1:0];
				REG_BASE_RATE_3:     cfg_q.base_rate[3] <= pwdata[BASE_W-1:0];
				REG_ALLOWED_CODES_0: cfg_q.allowed[0]   <= pwdata[MASK_W-1:0];
				REG_ALLOWED_CODES_1: cfg_q.allowed[1]   <= pwdata[MASK_W-1:0];
				REG_ALLOWED_CODES_2: cfg_q.allowed[2]   <= pwdata[MASK_W-1:0];
				REG_ALLOWED_CODES_3: cfg_q.allowed[3]   <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE_RATE_0:     prdata = DATA_W'(cfg_q.base_rate[0]);
			REG_BASE_RATE_1:     prdata = DATA_W'(cfg_q.base_rate[1]);
			REG_BASE_RATE_2:     prdata = DATA_W'(cfg_q.base_rate[2]);
			REG_BASE_RATE_3:     prdata = DATA_W'(cfg_q.base_rate[3]);
			REG_ALLOWED_CODES_0: prdata = DATA_W'(cfg_q.allowed[0]);
			REG_ALLOWED_CODES_1: prdata = DATA_W'(cfg_q.allowed[1]);
			REG_ALLOWED_CODES_2: prdata = DATA_W'(cfg_q.allowed[2]);
			REG_ALLOWED_CODES_3: prdata = DATA_W'(cfg_q.allowed[3]);
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== rtl/srds_ctrl.sv =====
// Controller state machine sequencing setup, candidate scan, drain and result.
module srds_ctrl import srds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	output ctrl_cmd_t cmd
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BASES * NUM_CODES - 1);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             out_valid_q, out_valid_d;
	logic             in_fire;

	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx  = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_NEED;
				end
			end
			ST_NEED: begin
				cmd.calc_need = 1'b1;
				state_d       = ST_WIN;
			end
			ST_WIN: begin
				cmd.calc_win   = 1'b1;
				cmd.clear_best = 1'b1;
				idx_d          = '0;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				idx_d     = idx_q + 1'b1;
				if (idx_q == LAST_IDX) begin
					idx_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				idx_d = idx_q + 1'b1;
				if (idx_q[0]) begin
					idx_d   = '0;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_NEED)
		else $error("accepted beat did not start setup");

	a_scan_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WIN |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("scan did not start at candidate zero");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_q == LAST_IDX) |=> state_q == ST_DRAIN)
		else $error("scan did not stop after last candidate");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (out_valid_q && state_q == ST_IDLE))
		else $error("loaded result not presented");

endmodule

// ===== rtl/srds_dp.sv =====
// Datapath: scaled request windows, candidate products, scoring and best tracking.
module srds_dp import srds_pkg::*; #(
	parameter int RATE_SCALE      = DEF_RATE_SCALE,
	parameter int HALF_FLAG_SHIFT = DEF_HALF_FLAG_SHIFT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	input  cfg_t              cfg,
	input  logic [RATE_W-1:0] adc_rate,
	input  logic [RATE_W-1:0] dac_rate,
	output logic              found,
	output logic [BIDX_W-1:0] base_index,
	output logic [CIDX_W-1:0] code_index,
	output logic              half_clock,
	output logic [WORD_W-1:0] rate_word,
	output logic [ERR_W-1:0]  best_error
);

	localparam logic [SCALE_W-1:0] SCALE       = SCALE_W'(RATE_SCALE);
	localparam logic               HALF_IN_WORD = (HALF_FLAG_SHIFT == WORD_HALF_BIT);

	logic [RATE_W-1:0]  adc_q, dac_q;
	logic [NEED_W-1:0]  tgt_adc_q, tgt_dac_q;
	logic [WIN_W-1:0]   adc_lo_q, adc_hi_q, dac_lo_q, dac_hi_q;

	logic               en_s1, en_s2;
	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [CAND_W-1:0]  adc_s1, dac_s1;
	logic               full_hit_s2, half_hit_s2;
	logic [SCORE_W-1:0] full_score_s2, half_score_s2;

	logic               have_q;
	logic [SCORE_W-1:0] best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               best_half_q;

	logic [BIDX_W-1:0]  sel_b;
	logic [CIDX_W-1:0]  sel_c;
	logic [CAND_W-1:0]  base_ext, adc_m_ext, dac_m_ext;

	logic               full_hit, half_hit;
	logic [SCORE_W-1:0] full_score, half_score;

	logic               full_win, half_win, mid_have;
	logic [SCORE_W-1:0] mid_best;

	function automatic logic in_window(input logic [CAND_W-1:0] cand,
		input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
		logic [WIN_W-1:0] c;
		c = WIN_W'(cand);
		return (c >= lo) && (c <= hi);
	endfunction

	function automatic logic [NEED_W-1:0] abs_err(input logic [NEED_W-1:0] need,
		input logic [CAND_W-1:0] cand);
		logic [NEED_W-1:0] c;
		c = NEED_W'(cand);
		return (need >= c) ? (need - c) : (c - need);
	endfunction

	assign sel_b     = cmd.idx[IDX_W-1:CIDX_W];
	assign sel_c     = cmd.idx[CIDX_W-1:0];
	assign base_ext  = CAND_W'(cfg.base_rate[sel_b]);
	assign adc_m_ext = CAND_W'(adc_mult(sel_c));
	assign dac_m_ext = CAND_W'(dac_mult(sel_c));

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			adc_q <= adc_rate;
			dac_q <= dac_rate;
		end
		if (cmd.calc_need) begin
			tgt_adc_q <= NEED_W'(adc_q) * NEED_W'(SCALE);
			tgt_dac_q <= NEED_W'(dac_q) * NEED_W'(SCALE);
		end
		if (cmd.calc_win) begin
			adc_lo_q <= WIN_W'(tgt_adc_q) - WIN_W'(tgt_adc_q >> 5);
			adc_hi_q <= WIN_W'(tgt_adc_q) + WIN_W'(tgt_adc_q >> 5);
			dac_lo_q <= WIN_W'(tgt_dac_q) - WIN_W'(tgt_dac_q >> 5);
			dac_hi_q <= WIN_W'(tgt_dac_q) + WIN_W'(tgt_dac_q >> 5);
		end
		idx_s1 <= cmd.idx;
		adc_s1 <= base_ext * adc_m_ext;
		dac_s1 <= base_ext * dac_m_ext;
		idx_s2        <= idx_s1;
		full_hit_s2   <= full_hit;
		half_hit_s2   <= half_hit;
		full_score_s2 <= full_score;
		half_score_s2 <= half_score;
	end

	always_comb begin
		full_hit   = in_window(adc_s1, adc_lo_q, adc_hi_q) &&
			in_window(dac_s1, dac_lo_q, dac_hi_q);
		half_hit   = in_window(adc_s1 >> 1, adc_lo_q, adc_hi_q) &&
			in_window(dac_s1 >> 1, dac_lo_q, dac_hi_q);
		full_score = SCORE_W'(abs_err(tgt_adc_q, adc_s1)) +
			SCORE_W'(abs_err(tgt_dac_q, dac_s1));
		half_score = SCORE_W'(abs_err(tgt_adc_q, adc_s1 >> 1)) +
			SCORE_W'(abs_err(tgt_dac_q, dac_s1 >> 1));
	end

	always_comb begin
		full_win = en_s2 && full_hit_s2 && (!have_q || full_score_s2 < best_q);
		mid_have = have_q || full_win;
		mid_best = full_win ? full_score_s2 : best_q;
		half_win = en_s2 && half_hit_s2 && (!mid_have || half_score_s2 <= mid_best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			en_s2  <= 1'b0;
			have_q <= 1'b0;
		end else begin
			en_s1 <= cmd.issue && cfg.allowed[sel_b][sel_c];
			en_s2 <= en_s1;
			if (cmd.clear_best) begin
				have_q <= 1'b0;
			end else if (full_win || half_win) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_best) begin
			best_q      <= '0;
			best_idx_q  <= '0;
			best_half_q <= 1'b0;
		end else if (half_win) begin
			best_q      <= half_score_s2;
			best_idx_q  <= idx_s2;
			best_half_q <= 1'b1;
		end else if (full_win) begin
			best_q      <= full_score_s2;
			best_idx_q  <= idx_s2;
			best_half_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found <= have_q;
			if (have_q) begin
				base_index <= best_idx_q[IDX_W-1:CIDX_W];
				code_index <= best_idx_q[CIDX_W-1:0];
				half_clock <= best_half_q;
				rate_word  <= {best_half_q & HALF_IN_WORD, best_idx_q[CIDX_W-1:0],
					best_idx_q[IDX_W-1:CIDX_W]};
				best_error <= best_q[ERR_W-1:0];
			end else begin
				base_index <= '0;
				code_index <= '0;
				half_clock <= 1'b0;
				rate_word  <= '0;
				best_error <= '0;
			end
		end
	end

endmodule

// ===== rtl/sample_rate_divider_search_core.sv =====
// Top level of the sample rate divider search: registers, controller and datapath.
//
// Usage: a request beat on in_ch carries the wanted ADC and DAC sample rates.
// Both are scaled by RATE_SCALE and given a window of +/- 1/32. The block then
// walks all 64 base/code pairs, one pair per cycle, checking each allowed pair
// at full and half rate, and returns one result beat on out_ch with the winning
// base, code, divider flag, packed rate word, score and a found flag.
// After a request is accepted the block scales it, forms the windows, scans
// all pairs through the single shared product/score pipeline, drains that
// pipeline and loads the result.
// in_ch.ready is high only while no search is running; a new request may be
// taken while the previous result still waits in the output register.
// If out_ch stalls, a finished search holds until the waiting result is taken.
// Reset clears the controller and restores the register defaults; the APB
// port (pready always high) is to be written by the user only while the block
// is idle, which the block itself does not enforce.
module sample_rate_divider_search_core import srds_pkg::*; #(
	parameter int RATE_SCALE      = DEF_RATE_SCALE,
	parameter int HALF_FLAG_SHIFT = DEF_HALF_FLAG_SHIFT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	srds_in_if.sink           in_ch,
	srds_out_if.source        out_ch
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;

	srds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	srds_dp #(
		.RATE_SCALE      (RATE_SCALE),
		.HALF_FLAG_SHIFT (HALF_FLAG_SHIFT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.adc_rate   (in_ch.adc_rate),
		.dac_rate   (in_ch.dac_rate),
		.found      (out_ch.found),
		.base_index (out_ch.base_index),
		.code_index (out_ch.code_index),
		.half_clock (out_ch.half_clock),
		.rate_word  (out_ch.rate_word),
		.best_error (out_ch.best_error)
	);

endmodule
